// ===== sv/secs_pkg.sv =====
`default_nettype none

package secs_pkg;

    localparam int NUM_CHANNELS_DEF = 65;
    localparam int NUM_TAPS         = 256;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_REPORT = 2'd2;

    localparam logic [5:0]  RATIO_RESET = 6'd18;
    localparam logic [15:0] SAMPLE_IDLE = 16'hFFFF;
    localparam logic [8:0]  WIDTH_MAX   = 9'd511;
    localparam logic [7:0]  TAP_MAX     = 8'd255;

    typedef struct packed {
        logic [15:0] last_sample;
        logic [7:0]  run_start;
        logic [8:0]  run_width;
        logic [7:0]  best_start;
        logic [8:0]  best_width;
    } t_rec;

    localparam t_rec REC_RESET = '{
        last_sample: SAMPLE_IDLE,
        run_start:   8'd0,
        run_width:   9'd0,
        best_start:  8'd0,
        best_width:  9'd0
    };

endpackage

`default_nettype wire

// ===== sv/serdes_eye_center_search_top.sv =====
// Eye centre search for serial-link input delay training.
// Input channel (i_in_valid / o_in_ready) carries one request: op, channel,
// tap and sample. Clear resets a channel's state, sample scores a word read
// at a delay tap, report returns the best eye of that channel.
// Output channel (o_out_valid / i_out_ready) carries one result per report:
// channel, eye start, eye width and eye centre.
// Configuration channel (i_cfg_valid / o_cfg_ready) writes the growth ratio
// in sixteenths; it is always ready.
// One request is taken every cycle while the output is not stalled. For a report,
// the state memory is read at the accepting edge, the forwarding and the
// width-times-ratio multiply feed the stage 2 registers, and the update and
// centre add feed the output register.
// Updates to the same channel in consecutive cycles are forwarded around the memory.
// Reset clears the pipeline, the per-channel valid bits (every channel reads
// as cleared) and sets the ratio to 18; no clearing pass is needed.
// While a result waits and i_out_ready is low the whole pipeline holds and
// o_in_ready is low; nothing is lost or repeated.
`default_nettype none

module serdes_eye_center_search_top
    import secs_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_cfg_valid,
    output      logic        o_cfg_ready,
    input  wire logic [5:0]  i_growth_ratio_sixteenths,

    input  wire logic        i_in_valid,
    output      logic        o_in_ready,
    input  wire logic [1:0]  i_op,
    input  wire logic [6:0]  i_channel,
    input  wire logic [7:0]  i_tap,
    input  wire logic [15:0] i_sample,

    output      logic        o_out_valid,
    input  wire logic        i_out_ready,
    output      logic [6:0]  o_report_channel,
    output      logic [7:0]  o_eye_start,
    output      logic [8:0]  o_eye_width,
    output      logic [7:0]  o_eye_center
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [5:0]  r_ratio;

    logic        en;
    logic        in_active;
    logic        ch_ok;
    logic [CH_W-1:0] rd_addr;

    // stage 1: memory read in flight
    logic        r_s1_vld;
    logic [1:0]  r_s1_op;
    logic [6:0]  r_s1_ch;
    logic [7:0]  r_s1_tap;
    logic [15:0] r_s1_sample;

    // stage 2: merged record, sample compare, score bar
    logic        r_s2_vld;
    logic [1:0]  r_s2_op;
    logic [6:0]  r_s2_ch;
    logic [7:0]  r_s2_tap;
    logic [15:0] r_s2_sample;
    t_rec        r_s2_rec;
    logic        r_s2_eq;
    logic [10:0] r_s2_bar;

    // last write into the memory, for forwarding
    logic        r_lw_vld;
    logic [6:0]  r_lw_ch;
    t_rec        r_lw_rec;

    logic        r_out_vld;
    logic [6:0]  r_out_ch;
    logic [7:0]  r_out_start;
    logic [8:0]  r_out_width;
    logic [7:0]  r_out_center;

    t_rec        ram_rd;
    t_rec        n_s1_rec;
    logic [14:0] n_prod;
    t_rec        n_upd;
    logic        s2_wr;
    logic [9:0]  n_center;

    assign en          = !r_out_vld || i_out_ready;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio <= RATIO_RESET;
        end else if (i_cfg_valid) begin
            r_ratio <= i_growth_ratio_sixteenths;
        end
    end

    assign ch_ok     = 8'(i_channel) < 8'(NUM_CHANNELS);
    assign in_active = ch_ok && ((i_op == OP_CLEAR) || (i_op == OP_REPORT) ||
                       ((i_op == OP_SAMPLE) && (10'(i_tap) < 10'(NUM_TAPS))));
    assign rd_addr   = ch_ok ? i_channel[CH_W-1:0] : '0;

    secs_state_ram #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (en),
        .i_rd_addr (rd_addr),
        .i_wr_en   (en && s2_wr),
        .i_wr_addr (r_s2_ch[CH_W-1:0]),
        .i_wr_data (n_upd),
        .o_rd_data (ram_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= i_in_valid && in_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_op     <= i_op;
            r_s1_ch     <= i_channel;
            r_s1_tap    <= i_tap;
            r_s1_sample <= i_sample;
        end
    end

    // newest copy of the channel: stage 2 update, then last write, then memory
    always_comb begin
        if (s2_wr && (r_s2_ch == r_s1_ch)) begin
            n_s1_rec = n_upd;
        end else if (r_lw_vld && (r_lw_ch == r_s1_ch)) begin
            n_s1_rec = r_lw_rec;
        end else begin
            n_s1_rec = ram_rd;
        end
    end

    assign n_prod = 15'(n_s1_rec.best_width * r_ratio);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (en) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_op     <= r_s1_op;
            r_s2_ch     <= r_s1_ch;
            r_s2_tap    <= r_s1_tap;
            r_s2_sample <= r_s1_sample;
            r_s2_rec    <= n_s1_rec;
            r_s2_eq     <= n_s1_rec.last_sample == r_s1_sample;
            r_s2_bar    <= n_prod[14:4];
        end
    end

    assign s2_wr = r_s2_vld && (r_s2_op != OP_REPORT);

    always_comb begin
        n_upd = r_s2_rec;
        if (r_s2_op == OP_CLEAR) begin
            n_upd = REC_RESET;
        end else begin
            if (r_s2_eq) begin
                if (r_s2_rec.run_width < WIDTH_MAX) begin
                    n_upd.run_width = r_s2_rec.run_width + 9'd1;
                end
            end else begin
                if (11'(r_s2_rec.run_width) > r_s2_bar) begin
                    n_upd.best_start = r_s2_rec.run_start;
                    n_upd.best_width = r_s2_rec.run_width;
                end
                n_upd.run_width = 9'd0;
                n_upd.run_start = r_s2_tap;
            end
            n_upd.last_sample = r_s2_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lw_vld <= 1'b0;
        end else if (en) begin
            r_lw_vld <= s2_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lw_ch  <= r_s2_ch;
            r_lw_rec <= n_upd;
        end
    end

    assign n_center = 10'(r_s2_rec.best_start) + 10'(r_s2_rec.best_width[8:1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_s2_vld && (r_s2_op == OP_REPORT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_ch     <= r_s2_ch;
            r_out_start  <= r_s2_rec.best_start;
            r_out_width  <= r_s2_rec.best_width;
            r_out_center <= (n_center > 10'(TAP_MAX)) ? TAP_MAX : n_center[7:0];
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_report_channel = r_out_ch;
    assign o_eye_start      = r_out_start;
    assign o_eye_width      = r_out_width;
    assign o_eye_center     = r_out_center;

endmodule

`default_nettype wire

// ===== sv/secs_state_ram.sv =====
`default_nettype none

module secs_state_ram
    import secs_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_rd_en,
    input  wire logic [CH_W-1:0] i_rd_addr,
    input  wire logic            i_wr_en,
    input  wire logic [CH_W-1:0] i_wr_addr,
    input  wire t_rec            i_wr_data,
    output      t_rec            o_rd_data
);

    t_rec                    r_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_vld;
    t_rec                    r_rd;
    logic                    r_rd_vld;

    // entries never written since reset read as the cleared record
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (i_rd_en) begin
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd : REC_RESET;

endmodule

`default_nettype wire

// ===== test/tb_serdes_eye_center_search_top.sv =====
`timescale 1ns / 100ps

module tb_serdes_eye_center_search_top;
    import secs_pkg::*;

    localparam int NUM_CH      = NUM_CHANNELS_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_SHOWN   = 10;

    typedef struct packed {
        logic [1:0]  op;
        logic [6:0]  channel;
        logic [7:0]  tap;
        logic [15:0] sample;
    } req_t;

    typedef struct packed {
        logic [6:0] channel;
        logic [7:0] start;
        logic [8:0] width;
        logic [7:0] centre;
    } eye_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [5:0]  i_growth_ratio_sixteenths = RATIO_RESET;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_op = OP_CLEAR;
    logic [6:0]  i_channel = 7'd0;
    logic [7:0]  i_tap = 8'd0;
    logic [15:0] i_sample = 16'd0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [6:0]  o_report_channel;
    logic [7:0]  o_eye_start;
    logic [8:0]  o_eye_width;
    logic [7:0]  o_eye_center;

    req_t req_q[$];
    eye_t eye_q[$];
    eye_t want;

    logic [15:0] trk_last_word  [NUM_CH];
    logic [7:0]  trk_run_start  [NUM_CH];
    logic [8:0]  trk_run_width  [NUM_CH];
    logic [7:0]  trk_best_start [NUM_CH];
    logic [8:0]  trk_best_width [NUM_CH];
    logic [5:0]  trk_ratio;

    int send_idle_pct = 16;
    int recv_idle_pct = 57;
    int n_accepted = 0;
    int n_reports = 0;
    int n_errors = 0;
    int n_ratio_writes = 0;
    int quiet_cycles = 0;

    serdes_eye_center_search_top uut (
        .i_clk                     (i_clk),
        .i_rst_n                   (i_rst_n),
        .i_cfg_valid               (i_cfg_valid),
        .o_cfg_ready               (o_cfg_ready),
        .i_growth_ratio_sixteenths (i_growth_ratio_sixteenths),
        .i_in_valid                (i_in_valid),
        .o_in_ready                (o_in_ready),
        .i_op                      (i_op),
        .i_channel                 (i_channel),
        .i_tap                     (i_tap),
        .i_sample                  (i_sample),
        .o_out_valid               (o_out_valid),
        .i_out_ready               (i_out_ready),
        .o_report_channel          (o_report_channel),
        .o_eye_start               (o_eye_start),
        .o_eye_width               (o_eye_width),
        .o_eye_center              (o_eye_center)
    );

    always #5 i_clk = ~i_clk;

    function automatic void clear_track(int c);
        trk_last_word[c]  = SAMPLE_IDLE;
        trk_run_start[c]  = 8'd0;
        trk_run_width[c]  = 9'd0;
        trk_best_start[c] = 8'd0;
        trk_best_width[c] = 9'd0;
    endfunction

    function automatic void apply_request(req_t r);
        int c;
        int bar;
        int centre;
        eye_t e;
        c = r.channel;
        if (c >= NUM_CH) return;
        case (r.op)
            OP_CLEAR: begin
                clear_track(c);
            end
            OP_SAMPLE: begin
                if (r.sample == trk_last_word[c]) begin
                    if (trk_run_width[c] < WIDTH_MAX)
                        trk_run_width[c] = trk_run_width[c] + 9'd1;
                end else begin
                    bar = (int'(trk_best_width[c]) * int'(trk_ratio)) >> 4;
                    if (int'(trk_run_width[c]) > bar) begin
                        trk_best_start[c] = trk_run_start[c];
                        trk_best_width[c] = trk_run_width[c];
                    end
                    trk_run_width[c] = 9'd0;
                    trk_run_start[c] = r.tap;
                end
                trk_last_word[c] = r.sample;
            end
            OP_REPORT: begin
                centre = int'(trk_best_start[c]) + (int'(trk_best_width[c]) >> 1);
                if (centre > int'(TAP_MAX)) centre = int'(TAP_MAX);
                e.channel = r.channel;
                e.start   = trk_best_start[c];
                e.width   = trk_best_width[c];
                e.centre  = 8'(centre);
                eye_q.push_back(e);
            end
            default: ;
        endcase
    endfunction

    function automatic void push_req(logic [1:0] op, int ch, int tap, logic [15:0] smp);
        req_q.push_back({op, 7'(ch), 8'(tap), smp});
    endfunction

    // interleaved tap sweeps over up to four channels, with some stray requests
    task automatic queue_sweeps(input int n_req, input int n_lanes);
        int          ch[4];
        int          tap[4];
        int          left[4];
        int          seg[4];
        int          stage[4];
        logic [15:0] word[4];
        int          made;
        int          k;
        int          op;
        int          nch;
        for (k = 0; k < 4; k++) begin
            stage[k] = 0;
            word[k]  = 16'($urandom);
        end
        made = 0;
        while (made < n_req) begin
            k = $urandom_range(n_lanes - 1);
            if ($urandom_range(99) < 8) begin
                op  = $urandom_range(3);
                nch = $urandom_range(127);
                push_req(2'(op), nch, $urandom_range(255), 16'($urandom));
                if (op != 3 && nch < NUM_CH) made++;
            end else begin
                case (stage[k])
                    0: begin
                        ch[k] = $urandom_range(NUM_CH - 1);
                        if ($urandom_range(99) < 80) begin
                            push_req(OP_CLEAR, ch[k], 0, 16'd0);
                            made++;
                        end
                        tap[k]   = $urandom_range(1) ? 0 : $urandom_range(255);
                        left[k]  = $urandom_range(10, 70);
                        seg[k]   = 0;
                        stage[k] = 1;
                    end
                    1: begin
                        if (seg[k] == 0) begin
                            case ($urandom_range(3))
                                0: word[k] = SAMPLE_IDLE;
                                1: word[k] = word[k] ^ (16'h1 << $urandom_range(15));
                                default: word[k] = 16'($urandom);
                            endcase
                            seg[k] = ($urandom_range(3) == 0) ? $urandom_range(1, 2)
                                                              : $urandom_range(3, 30);
                        end
                        push_req(OP_SAMPLE, ch[k], tap[k], word[k]);
                        made++;
                        tap[k] = ($urandom_range(19) == 0) ? $urandom_range(255)
                                                           : (tap[k] + 1) % 256;
                        seg[k]--;
                        left[k]--;
                        if ($urandom_range(99) < 5) begin
                            push_req(OP_REPORT, ch[k], 0, 16'd0);
                            made++;
                        end
                        if (left[k] == 0) stage[k] = 2;
                    end
                    default: begin
                        push_req(OP_REPORT, ch[k], $urandom_range(255), 16'($urandom));
                        made++;
                        stage[k] = 0;
                    end
                endcase
            end
        end
        for (k = 0; k < n_lanes; k++) begin
            if (stage[k] != 0) push_req(OP_REPORT, ch[k], 0, 16'd0);
        end
    endtask

    task automatic drain_all();
        @(posedge i_clk);
        while (req_q.size() != 0 || i_in_valid || eye_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_ratio(input logic [5:0] value);
        i_cfg_valid <= 1'b1;
        i_growth_ratio_sixteenths <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        trk_ratio = value;
        n_ratio_writes++;
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                apply_request({i_op, i_channel, i_tap, i_sample});
                n_accepted++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    {i_op, i_channel, i_tap, i_sample} <= req_q.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // report monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                n_reports++;
                if (eye_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_SHOWN)
                        $display("unexpected report: ch %0d start %0d width %0d centre %0d",
                                 o_report_channel, o_eye_start, o_eye_width, o_eye_center);
                end else begin
                    want = eye_q.pop_front();
                    if (o_report_channel !== want.channel || o_eye_start !== want.start ||
                        o_eye_width !== want.width || o_eye_center !== want.centre) begin
                        n_errors++;
                        if (n_errors <= MAX_SHOWN)
                            $display("report mismatch: expected ch %0d start %0d width %0d %s%0d, %s",
                                     want.channel, want.start, want.width, "centre ",
                                     want.centre, "got:");
                        if (n_errors <= MAX_SHOWN)
                            $display("    got ch %0d start %0d width %0d centre %0d",
                                     o_report_channel, o_eye_start, o_eye_width, o_eye_center);
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: nothing moved for %0d cycles", STALL_LIMIT);
            $display("tb_serdes_eye_center_search_top: FAIL");
            $finish;
        end
    end

    initial begin
        logic [5:0]  ratios[6];
        logic [15:0] long_word;
        int          long_ch;
        int          p;
        int          t;
        trk_ratio = RATIO_RESET;
        for (t = 0; t < NUM_CH; t++) clear_track(t);
        ratios[0] = 6'd16;
        ratios[1] = 6'd32;
        ratios[2] = 6'd0;
        ratios[3] = 6'd63;
        ratios[4] = 6'($urandom_range(17, 31));
        ratios[5] = RATIO_RESET;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset state, channel limits, ignored requests
        push_req(OP_REPORT, 0, 0, 16'd0);
        push_req(OP_REPORT, NUM_CH - 1, 255, 16'hFFFF);
        push_req(2'd3, 0, 12, 16'h1234);
        push_req(OP_REPORT, NUM_CH, 0, 16'd0);
        push_req(OP_SAMPLE, 127, 170, 16'h5555);
        push_req(OP_CLEAR, 100, 0, 16'd0);
        // one-tap eye on the top channel, then clear it
        push_req(OP_SAMPLE, NUM_CH - 1, 255, 16'hFFFF);
        push_req(OP_SAMPLE, NUM_CH - 1, 0, 16'h0000);
        push_req(OP_REPORT, NUM_CH - 1, 0, 16'd0);
        push_req(OP_CLEAR, NUM_CH - 1, 0, 16'd0);
        push_req(OP_REPORT, NUM_CH - 1, 0, 16'd0);
        // eye near the top tap so the centre clamps
        push_req(OP_SAMPLE, 1, 250, 16'hA5A5);
        for (t = 1; t <= 12; t++) push_req(OP_SAMPLE, 1, 250 + t, 16'hA5A5);
        push_req(OP_SAMPLE, 1, 7, 16'h5A5A);
        push_req(OP_REPORT, 1, 0, 16'd0);
        drain_all();

        for (p = 0; p < 6; p++) begin
            if (p == 2) begin
                send_idle_pct = 57;
                recv_idle_pct = 16;
            end
            if (p == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            repeat (6) @(posedge i_clk);
            write_ratio(ratios[p]);
            queue_sweeps(50, 1 + p % 4);
            if (p == 4) begin
                // run long enough to saturate the width counter
                long_ch   = $urandom_range(NUM_CH - 1);
                long_word = 16'($urandom);
                if (long_word == SAMPLE_IDLE) long_word = 16'h1234;
                push_req(OP_CLEAR, long_ch, 0, 16'd0);
                for (t = 0; t < 522; t++) push_req(OP_SAMPLE, long_ch, 3 + t, long_word);
                push_req(OP_SAMPLE, long_ch, 200, ~long_word);
                push_req(OP_REPORT, long_ch, 0, 16'd0);
            end
            // sender holds off until every report is back
            drain_all();
            queue_sweeps(50, 2);
            drain_all();
        end

        repeat (8) @(posedge i_clk);
        if (eye_q.size() != 0) begin
            $display("%0d expected reports never arrived", eye_q.size());
            n_errors += eye_q.size();
        end
        $display("%0d requests accepted, %0d eye reports checked, %0d mismatches",
                 n_accepted, n_reports, n_errors);
        $display("ratio written %0d times (0, 16, 32, 63 among them); interleaved sweeps, %s",
                 n_ratio_writes, "glitches, a saturated run and centre clamp covered");
        if (n_errors == 0) begin
            $display("tb_serdes_eye_center_search_top: PASS");
        end else begin
            $display("tb_serdes_eye_center_search_top: FAIL");
        end
        $finish;
    end

endmodule
